FILE: sv/mptr_pkg.sv
`default_nettype none
package mptr_pkg;

  localparam int PACKET_BYTES = 3;
  localparam int POS_W        = 2;
  localparam int STORE_DEPTH  = 3;
  localparam int CFG_INDEX_W  = 2;

  // Both internal queues hold two words.
  localparam logic [1:0] QUEUE_FULL = 2'd2;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_COLUMNS = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_ROWS    = CFG_INDEX_W'(1);

  localparam logic [7:0] AUX_FLAG     = 8'h20;
  localparam logic [7:0] RESET_COLS   = 8'd80;
  localparam logic [7:0] RESET_ROWS   = 8'd25;
  localparam logic [7:0] RESET_CUR_X  = 8'd40;
  localparam logic [7:0] RESET_CUR_Y  = 8'd12;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [1:0]  button_index;
    logic [7:0]  cursor_column;
    logic [7:0]  cursor_row;
    logic        last_event;
  } out_word_t;

  typedef struct packed {
    logic [2:0] buttons;
    logic [7:0] dx;
    logic [7:0] dy;
  } packet_t;

  typedef struct packed {
    logic                   valid;
    logic [CFG_INDEX_W-1:0] index;
    logic [7:0]             data;
  } cfg_write_t;

endpackage
`default_nettype wire

FILE: sv/mptr_front.sv
`default_nettype none
module mptr_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire mptr_pkg::in_word_t in_data,
  output logic                   in_full,
  output logic                   pkt_valid,
  output mptr_pkg::packet_t      pkt_data,
  input  wire logic              pkt_pop
);

  logic [mptr_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0] store_r [mptr_pkg::STORE_DEPTH];
  logic [7:0] merged [mptr_pkg::STORE_DEPTH];

  mptr_pkg::packet_t q_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  logic take, last_byte, q_push, q_pop;

  always_comb begin
    in_full   = (cnt_r == mptr_pkg::QUEUE_FULL);
    take      = in_push && !in_full && ((in_data.status_byte & mptr_pkg::AUX_FLAG) != 8'd0);
    last_byte = (pos_r == mptr_pkg::LAST_POS);
    q_push    = take && last_byte;
    q_pop     = pkt_pop && (cnt_r != 2'd0);

    // The byte arriving now completes the packet, so it stands in for its own slot.
    for (int k = 0; k < mptr_pkg::STORE_DEPTH; k++) begin
      merged[k] = (pos_r == mptr_pkg::POS_W'(k)) ? in_data.data_byte : store_r[k];
    end

    pos_nxt = pos_r;
    if (take) begin
      pos_nxt = last_byte ? '0 : pos_r + 1'b1;
    end

    wp_nxt  = q_push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, q_push} - {1'b0, q_pop};

    pkt_valid = (cnt_r != 2'd0);
    pkt_data  = q_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      pos_r <= pos_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mptr_pkg::STORE_DEPTH; k++) begin
      if (take && pos_r == mptr_pkg::POS_W'(k)) begin
        store_r[k] <= in_data.data_byte;
      end
    end
    if (q_push) begin
      q_r[wp_r] <= '{buttons: merged[0][2:0], dx: merged[1], dy: merged[2]};
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mptr_pkg::QUEUE_FULL) else $error("packet queue count overflow");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mptr_pkg::LAST_POS) else $error("byte position past packet end");
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> cnt_r != 2'd0) else $error("completed packet not queued");
`endif

endmodule
`default_nettype wire

FILE: sv/mptr_back.sv
`default_nettype none
module mptr_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire mptr_pkg::cfg_write_t cfg_wr,
  input  wire logic                pkt_valid,
  input  wire mptr_pkg::packet_t   pkt_data,
  output logic                     pkt_pop,
  output logic                     out_empty,
  output mptr_pkg::out_word_t      out_data,
  input  wire logic                out_pop
);

  logic [7:0] cols_r, rows_r;
  logic [7:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0] btn_r, btn_nxt, newbtn_r, newbtn_nxt;
  // Bit 0 is the move event, bits 1 to 3 the three buttons.
  logic [3:0] mask_r, mask_nxt, sel, rem;

  mptr_pkg::out_word_t oq_r [2];
  mptr_pkg::out_word_t ev;
  logic       owp_r, owp_nxt, orp_r, orp_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;

  logic emit, load, o_pop, moved;
  logic [2:0] chg;
  logic [7:0] top_x, top_y;
  logic [9:0] nx, ny;

  always_comb begin
    top_x = (cols_r == 8'd0) ? 8'd0 : cols_r - 8'd1;
    top_y = (rows_r == 8'd0) ? 8'd0 : rows_r - 8'd1;
    nx = {2'b00, cx_r} + {{2{pkt_data.dx[7]}}, pkt_data.dx};
    ny = {2'b00, cy_r} - {{2{pkt_data.dy[7]}}, pkt_data.dy};
    moved = (pkt_data.dx != 8'd0) || (pkt_data.dy != 8'd0);
    chg   = pkt_data.buttons ^ btn_r;

    emit = (mask_r != 4'd0) && (ocnt_r != mptr_pkg::QUEUE_FULL);
    sel  = mask_r & (~mask_r + 4'd1);
    rem  = mask_r & ~sel;
    load = pkt_valid && ((mask_r == 4'd0) || (emit && rem == 4'd0));
    pkt_pop = load;

    ev = '{event_kind: mptr_pkg::EV_MOVE, button_index: 2'd0,
           cursor_column: cx_r, cursor_row: cy_r, last_event: (rem == 4'd0)};
    priority if (mask_r[0]) begin
      ev.event_kind = mptr_pkg::EV_MOVE;
    end else if (mask_r[1]) begin
      ev.button_index = 2'd0;
      ev.event_kind   = newbtn_r[0] ? mptr_pkg::EV_PRESS : mptr_pkg::EV_RELEASE;
    end else if (mask_r[2]) begin
      ev.button_index = 2'd1;
      ev.event_kind   = newbtn_r[1] ? mptr_pkg::EV_PRESS : mptr_pkg::EV_RELEASE;
    end else begin
      ev.button_index = 2'd2;
      ev.event_kind   = newbtn_r[2] ? mptr_pkg::EV_PRESS : mptr_pkg::EV_RELEASE;
    end

    mask_nxt   = emit ? rem : mask_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    btn_nxt    = btn_r;
    newbtn_nxt = newbtn_r;
    if (load) begin
      mask_nxt   = {chg, moved};
      btn_nxt    = pkt_data.buttons;
      newbtn_nxt = pkt_data.buttons;
      if (moved) begin
        cx_nxt = nx[9] ? 8'd0 : ((nx[8:0] > {1'b0, top_x}) ? top_x : nx[7:0]);
        cy_nxt = ny[9] ? 8'd0 : ((ny[8:0] > {1'b0, top_y}) ? top_y : ny[7:0]);
      end
    end

    o_pop    = out_pop && (ocnt_r != 2'd0);
    owp_nxt  = emit ? ~owp_r : owp_r;
    orp_nxt  = o_pop ? ~orp_r : orp_r;
    ocnt_nxt = ocnt_r + {1'b0, emit} - {1'b0, o_pop};

    out_empty = (ocnt_r == 2'd0);
    out_data  = oq_r[orp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r   <= mptr_pkg::RESET_COLS;
      rows_r   <= mptr_pkg::RESET_ROWS;
      cx_r     <= mptr_pkg::RESET_CUR_X;
      cy_r     <= mptr_pkg::RESET_CUR_Y;
      btn_r    <= 3'd0;
      mask_r   <= 4'd0;
      owp_r    <= 1'b0;
      orp_r    <= 1'b0;
      ocnt_r   <= 2'd0;
    end else begin
      if (cfg_wr.valid && cfg_wr.index == mptr_pkg::REG_SCREEN_COLUMNS) begin
        cols_r <= cfg_wr.data;
      end
      if (cfg_wr.valid && cfg_wr.index == mptr_pkg::REG_SCREEN_ROWS) begin
        rows_r <= cfg_wr.data;
      end
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      btn_r  <= btn_nxt;
      mask_r <= mask_nxt;
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newbtn_r <= newbtn_nxt;
    if (emit) begin
      oq_r[owp_r] <= ev;
    end
  end

`ifndef NO_ASSERTIONS
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= mptr_pkg::QUEUE_FULL) else $error("result queue count overflow");
  a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> ocnt_r != 2'd0) else $error("emitted event not queued");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (mask_r == 4'd0 || $onehot(mask_r))) else $error("packet loaded over pending events");
`endif

endmodule
`default_nettype wire

FILE: sv/mouse_packet_cursor_tracker.sv
`default_nettype none
// Mouse packet cursor tracker.
// Input side is a queue: a word {status_byte, data_byte} is taken when in_push is
// high and in_full low. Only words whose status has the auxiliary bit set count;
// every third such word completes a mouse packet.
// Result side is a queue too: while out_empty is low the oldest event sits on
// out_data and leaves on a cycle with out_pop high. A packet yields a move event
// (if either delta is nonzero) followed by press/release events for buttons 0, 1
// and 2 that changed; the final one carries last_event.
// The front part gathers bytes into packets and queues them two deep; the back
// part turns each packet into events, one per cycle while the result queue has room, into a two-word result queue.
// Words are taken one per cycle while the packet queue has room; a packet occupies
// the back part until it has produced its events (at most four), and the next
// packet may be taken in the same cycle as its last event. The first event of a
// packet reaches out_data through the packet queue, the event mask and the result queue.
// When the receiver stalls, the result queue fills, the back part holds, the
// packet queue fills and in_full rises. The cfg channel is always ready.
// Reset (rst_n low, synchronous) empties both queues, restarts packet assembly,
// clears the button state, puts the cursor at column 40 row 12 and the screen at
// 80 by 25.
module mouse_packet_cursor_tracker (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire mptr_pkg::in_word_t                 in_data,
  output logic                                    in_full,
  output logic                                    out_empty,
  output mptr_pkg::out_word_t                     out_data,
  input  wire logic                               out_pop,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mptr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [7:0]                         cfg_data
);

  logic               pkt_valid, pkt_pop;
  mptr_pkg::packet_t  pkt_data;
  mptr_pkg::cfg_write_t cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};

  mptr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .pkt_valid (pkt_valid),
    .pkt_data  (pkt_data),
    .pkt_pop   (pkt_pop)
  );

  mptr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .pkt_valid (pkt_valid),
    .pkt_data  (pkt_data),
    .pkt_pop   (pkt_pop),
    .out_empty (out_empty),
    .out_data  (out_data),
    .out_pop   (out_pop)
  );

endmodule
`default_nettype wire
